### src/bscm_pkg.sv
// Package for the bike speed and cadence meter: shared types, codes and constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package bscm_pkg;

    localparam int RADIUS_W   = 10;
    localparam int ODO_W      = 40;
    localparam int WGAP_W     = 10;
    localparam int CGAP_W     = 20;
    localparam int IDLE_W     = 16;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;

    localparam int CMD_W      = 3;
    localparam int TIME_W     = 32;
    localparam int SPEED_W    = 16;
    localparam int CAD_W      = 9;
    localparam int TRIP_W     = 32;

    localparam int TWO_PI_W   = 19;
    localparam int PROD_W     = RADIUS_W + TWO_PI_W;
    localparam int CIRC_W     = PROD_W - 16;
    localparam int SCALE_W    = 9;
    localparam int NUM_W      = 26;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    // 2*pi in Q16
    localparam logic [TWO_PI_W-1:0] TWO_PI_Q16  = 19'd411775;
    localparam logic [SCALE_W-1:0]  SPEED_SCALE = 9'd360;
    localparam logic [NUM_W-1:0]    CAD_SCALE   = 26'd60000000;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 10'd340;
    localparam logic [WGAP_W-1:0]   WGAP_RST   = 10'd90;
    localparam logic [CGAP_W-1:0]   CGAP_RST   = 20'd170000;
    localparam logic [IDLE_W-1:0]   IDLE_RST   = 16'd8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_WHEEL    = 3'd1,
        CMD_CRANK    = 3'd2,
        CMD_TRIP_RST = 3'd3,
        CMD_ODO_LOAD = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHEEL_RADIUS = 3'd0,
        CFG_ODO_PRESET   = 3'd1,
        CFG_WHEEL_GAP    = 3'd2,
        CFG_CRANK_GAP    = 3'd3,
        CFG_IDLE_TIMEOUT = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CHECK,
        ST_CIRC,
        ST_SCALE,
        ST_LAUNCH,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] wheel_radius;
        logic [ODO_W-1:0]    odo_preset;
        logic [WGAP_W-1:0]   wheel_min_gap;
        logic [CGAP_W-1:0]   crank_min_gap;
        logic [IDLE_W-1:0]   idle_timeout;
    } cfg_t;

    typedef struct packed {
        logic               accepted;
        logic               timed_out;
        logic [SPEED_W-1:0] speed;
        logic [CAD_W-1:0]   cadence;
        logic [TRIP_W-1:0]  trip;
        logic [ODO_W-1:0]   odometer;
        logic               running;
    } res_t;

endpackage

`default_nettype wire

### src/bike_speed_cadence_meter_unit.sv
// Bike speed and cadence meter: top level with config registers and output stage.
// Depends on bscm_pkg, bscm_core and bscm_div.
//
// Usage:
//   s_ channel carries one event request: s_tuser is the command (tick, wheel
//   pulse, crank pulse, trip reset, odometer load), s_tdata the ms and us
//   timestamps. Each request yields exactly one result request on m_.
//   Config registers are written through cfg_wr_en/cfg_index/cfg_wdata while
//   the block is idle; writes take effect at the next clock edge.
// Sequencing: a request passes ST_DIFF, ST_CHECK and ST_DONE for ticks, trip reset,
//   odometer load and rejected pulses; an accepted wheel pulse also passes ST_CIRC,
//   ST_SCALE, ST_LAUNCH, ST_DIV and ST_UPDATE, and an accepted crank pulse all of
//   these but ST_CIRC. ST_DIV waits on the 26-step serial divider shared by the
//   speed and cadence quotients. One request is in flight at a time.
// s_tready is high while the sequencer is idle, even if a result still waits
//   in the output register; a finished result waits in the sequencer until
//   the output register is free, so m_tready low stalls the block there.
// Reset (aresetn low, synchronous): all meter state cleared, config registers
//   back to their defaults, no result pending.
`default_nettype none

module bike_speed_cadence_meter_unit
    import bscm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [63:0]           s_tdata,  // time_ms, time_us
    input  wire logic [CMD_W-1:0]      s_tuser,  // cmd
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [103:0]               m_tdata,  // speed_x100, cadence_rpm, trip_mm,
                                                 // odometer_mm, trip_running, zero pad
    output logic [1:0]                 m_tuser,  // accepted, timed_out
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg, cfg_next;
    logic m_valid_reg, m_valid_next;
    res_t m_res_reg, m_res_next;
    res_t core_res;
    logic core_res_valid;
    logic out_free;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WHEEL_RADIUS: cfg_next.wheel_radius  = cfg_wdata[RADIUS_W-1:0];
                CFG_ODO_PRESET:   cfg_next.odo_preset    = cfg_wdata[ODO_W-1:0];
                CFG_WHEEL_GAP:    cfg_next.wheel_min_gap = cfg_wdata[WGAP_W-1:0];
                CFG_CRANK_GAP:    cfg_next.crank_min_gap = cfg_wdata[CGAP_W-1:0];
                CFG_IDLE_TIMEOUT: cfg_next.idle_timeout  = cfg_wdata[IDLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    bscm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_ms     (s_tdata[31:0]),
        .in_us     (s_tdata[63:32]),
        .out_free  (out_free),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (core_res_valid) begin
            m_valid_next = 1'b1;
            m_res_next   = core_res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wheel_radius  <= RADIUS_RST;
            cfg_reg.odo_preset    <= '0;
            cfg_reg.wheel_min_gap <= WGAP_RST;
            cfg_reg.crank_min_gap <= CGAP_RST;
            cfg_reg.idle_timeout  <= IDLE_RST;
            m_valid_reg           <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {m_res_reg.timed_out, m_res_reg.accepted};
    assign m_tdata  = {6'd0, m_res_reg.running, m_res_reg.odometer, m_res_reg.trip,
                       m_res_reg.cadence, m_res_reg.speed};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted a request while the previous one was in flight");

    a_result_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        core_res_valid |-> (!m_valid_reg || m_tready))
        else $error("result issued into an occupied output register");

    a_timeout_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata[24:0] == 25'd0))
        else $error("timeout result with nonzero speed or cadence");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("accepted and timed_out set together");
`endif

endmodule

`default_nettype wire

### src/bscm_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on bscm_pkg.
`default_nettype none

module bscm_div
    import bscm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  dividend,
    input  wire logic [TIME_W-1:0] divisor,
    output logic                   done,
    output logic [NUM_W-1:0]       quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [TIME_W-1:0]    dvs_reg, dvs_next;
    logic [NUM_W:0]       trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = TIME_W'(trial) >= dvs_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? NUM_W'(trial - (NUM_W+1)'(dvs_reg)) : trial[NUM_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### src/bscm_core.sv
// Sequencer and meter state: gap checks, circumference, saturating updates.
// Depends on bscm_pkg and bscm_div.
`default_nettype none

module bscm_core
    import bscm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  in_cmd,
    input  wire logic [TIME_W-1:0] in_ms,
    input  wire logic [TIME_W-1:0] in_us,
    input  wire logic              out_free,
    output logic                   res_valid,
    output res_t                   res
);

    state_t state_reg, state_next;

    cmd_t               cmd_reg, cmd_next;
    logic [TIME_W-1:0]  ms_reg, ms_next;
    logic [TIME_W-1:0]  us_reg, us_next;
    logic [TIME_W-1:0]  diff_reg, diff_next;
    logic [CIRC_W-1:0]  circ_reg, circ_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic               acc_reg, acc_next;
    logic               tmo_reg, tmo_next;

    logic [TIME_W-1:0]  last_wheel_reg, last_wheel_next;
    logic [TIME_W-1:0]  last_crank_reg, last_crank_next;
    logic [TIME_W-1:0]  last_act_reg, last_act_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [CAD_W-1:0]   cad_reg, cad_next;
    logic [TRIP_W-1:0]  trip_reg, trip_next;
    logic [ODO_W-1:0]   odo_reg, odo_next;
    logic               run_reg, run_next;

    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_quo;
    logic [PROD_W-1:0]  circ_prod;
    logic [TRIP_W:0]    trip_sum;
    logic [ODO_W:0]     odo_sum;
    logic               tick_hit, wheel_hit, crank_hit;

    bscm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (diff_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign tick_hit  = diff_reg > TIME_W'(cfg.idle_timeout);
    assign wheel_hit = diff_reg > TIME_W'(cfg.wheel_min_gap);
    assign crank_hit = diff_reg > TIME_W'(cfg.crank_min_gap);

    assign circ_prod = PROD_W'(cfg.wheel_radius) * PROD_W'(TWO_PI_Q16);
    assign trip_sum  = {1'b0, trip_reg} + (TRIP_W+1)'(circ_reg);
    assign odo_sum   = {1'b0, odo_reg} + (ODO_W+1)'(circ_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (cmd_reg == CMD_WHEEL && wheel_hit) begin
                    state_next = ST_CIRC;
                end else if (cmd_reg == CMD_CRANK && crank_hit) begin
                    state_next = ST_SCALE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CIRC:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready  = 1'b1;
            ST_LAUNCH: div_start = 1'b1;
            ST_DONE:   res_valid = out_free;
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        cmd_next        = cmd_reg;
        ms_next         = ms_reg;
        us_next         = us_reg;
        diff_next       = diff_reg;
        circ_next       = circ_reg;
        num_next        = num_reg;
        acc_next        = acc_reg;
        tmo_next        = tmo_reg;
        last_wheel_next = last_wheel_reg;
        last_crank_next = last_crank_reg;
        last_act_next   = last_act_reg;
        speed_next      = speed_reg;
        cad_next        = cad_reg;
        trip_next       = trip_reg;
        odo_next        = odo_reg;
        run_next        = run_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next = cmd_t'(in_cmd);
                    ms_next  = in_ms;
                    us_next  = in_us;
                    acc_next = 1'b0;
                    tmo_next = 1'b0;
                end
            end
            ST_DIFF: begin
                unique case (cmd_reg)
                    CMD_TICK:  diff_next = ms_reg - last_act_reg;
                    CMD_WHEEL: diff_next = ms_reg - last_wheel_reg;
                    CMD_CRANK: diff_next = us_reg - last_crank_reg;
                    default:   diff_next = '0;
                endcase
            end
            ST_CHECK: begin
                unique case (cmd_reg)
                    CMD_TICK: begin
                        if (tick_hit) begin
                            speed_next    = '0;
                            cad_next      = '0;
                            last_act_next = ms_reg;
                            tmo_next      = 1'b1;
                        end
                    end
                    CMD_WHEEL: acc_next = wheel_hit;
                    CMD_CRANK: acc_next = crank_hit;
                    CMD_TRIP_RST: begin
                        trip_next = '0;
                        run_next  = 1'b0;
                    end
                    CMD_ODO_LOAD: odo_next = cfg.odo_preset;
                    default: begin
                    end
                endcase
            end
            ST_CIRC: circ_next = circ_prod[PROD_W-1:16];
            ST_SCALE: begin
                if (cmd_reg == CMD_WHEEL) begin
                    num_next = NUM_W'(circ_reg) * NUM_W'(SPEED_SCALE);
                end else begin
                    num_next = CAD_SCALE;
                end
            end
            ST_UPDATE: begin
                last_act_next = ms_reg;
                run_next      = 1'b1;
                if (cmd_reg == CMD_WHEEL) begin
                    speed_next      = (|div_quo[NUM_W-1:SPEED_W]) ? '1 : div_quo[SPEED_W-1:0];
                    trip_next       = trip_sum[TRIP_W] ? '1 : trip_sum[TRIP_W-1:0];
                    odo_next        = odo_sum[ODO_W] ? '1 : odo_sum[ODO_W-1:0];
                    last_wheel_next = ms_reg;
                end else begin
                    cad_next        = (|div_quo[NUM_W-1:CAD_W]) ? '1 : div_quo[CAD_W-1:0];
                    last_crank_next = us_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            acc_reg        <= 1'b0;
            tmo_reg        <= 1'b0;
            last_wheel_reg <= '0;
            last_crank_reg <= '0;
            last_act_reg   <= '0;
            speed_reg      <= '0;
            cad_reg        <= '0;
            trip_reg       <= '0;
            odo_reg        <= '0;
            run_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            tmo_reg        <= tmo_next;
            last_wheel_reg <= last_wheel_next;
            last_crank_reg <= last_crank_next;
            last_act_reg   <= last_act_next;
            speed_reg      <= speed_next;
            cad_reg        <= cad_next;
            trip_reg       <= trip_next;
            odo_reg        <= odo_next;
            run_reg        <= run_next;
        end
        cmd_reg  <= cmd_next;
        ms_reg   <= ms_next;
        us_reg   <= us_next;
        diff_reg <= diff_next;
        circ_reg <= circ_next;
        num_reg  <= num_next;
    end

    always_comb begin
        res.accepted  = acc_reg;
        res.timed_out = tmo_reg;
        res.speed     = speed_reg;
        res.cadence   = cad_reg;
        res.trip      = trip_reg;
        res.odometer  = odo_reg;
        res.running   = run_reg;
    end

endmodule

`default_nettype wire
